>>> rtl/jcm_pkg.sv
package jcm_pkg;

    // Register map of the configuration port
    typedef enum logic [1:0] {
        REG_REST_RADIUS = 2'd0,
        REG_FAST_GAIN   = 2'd1,
        REG_SLOW_GAIN   = 2'd2,
        REG_HOLD_DELAY  = 2'd3
    } jcm_reg_t;

    localparam logic [14:0] REST_RADIUS_RST = 15'd25000;
    localparam logic [31:0] FAST_GAIN_RST   = 32'd35791;
    localparam logic [31:0] SLOW_GAIN_RST   = 32'd7158;
    localparam logic [15:0] HOLD_DELAY_RST  = 16'd500;

    // Full-scale stick radius
    localparam logic [14:0] STICK_FULL = 15'd32767;

    // Integer root of a sum of two 16-bit squares: 16 result bits, one per step
    localparam int          ROOT_STEPS     = 16;
    localparam logic [31:0] ROOT_FIRST_BIT = 32'h4000_0000;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_SQD,
        OP_TEST,
        OP_ROOT,
        OP_OVER,
        OP_MX1,
        OP_MX2,
        OP_MY1,
        OP_MY2,
        OP_DINIT,
        OP_DIV,
        OP_MOVE
    } jcm_op_t;

    typedef struct packed {
        jcm_op_t op;
    } jcm_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } jcm_status_t;

    typedef struct packed {
        logic [14:0] rest_radius;
        logic [31:0] fast_gain;
        logic [31:0] slow_gain;
        logic [15:0] hold_delay_ms;
    } jcm_cfg_t;

endpackage

>>> rtl/jcm_ctrl.sv
module jcm_ctrl #(
    parameter int DIV_STEPS = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  jcm_pkg::jcm_status_t status,
    output jcm_pkg::jcm_cmd_t    cmd
);

    localparam int MAX_STEPS = (DIV_STEPS > jcm_pkg::ROOT_STEPS) ? DIV_STEPS
                                                                  : jcm_pkg::ROOT_STEPS;
    localparam int CW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [CW-1:0] ROOT_LAST = CW'(jcm_pkg::ROOT_STEPS - 1);
    localparam logic [CW-1:0] DIV_LAST  = CW'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQD,
        S_TEST,
        S_ROOT,
        S_OVER,
        S_MX1,
        S_MX2,
        S_MY1,
        S_MY2,
        S_DINIT,
        S_DIV,
        S_MOVE
    } state_t;

    state_t          state_reg;
    logic            ready_reg;
    logic [CW-1:0]   cnt_reg;

    assign s_tready = ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (!ready_reg) begin
                        ready_reg <= 1'b1;
                    end else if (s_tvalid) begin
                        ready_reg <= 1'b0;
                        state_reg <= S_SQX;
                    end
                end
                S_SQX:  state_reg <= S_SQY;
                S_SQY:  state_reg <= S_SQD;
                S_SQD:  state_reg <= S_TEST;
                S_TEST: begin
                    cnt_reg   <= '0;
                    // resting stick skips root, gain and divide
                    state_reg <= status.active ? S_ROOT : S_MOVE;
                end
                S_ROOT: begin
                    if (cnt_reg == ROOT_LAST) begin
                        state_reg <= S_OVER;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_OVER: state_reg <= S_MX1;
                S_MX1:  state_reg <= S_MX2;
                S_MX2:  state_reg <= S_MY1;
                S_MY1:  state_reg <= S_MY2;
                S_MY2:  state_reg <= S_DINIT;
                S_DINIT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= S_MOVE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MOVE: begin
                    // hold until the output register can take the item
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.op = jcm_pkg::OP_IDLE;
        unique case (state_reg)
            S_IDLE:  cmd.op = (ready_reg && s_tvalid) ? jcm_pkg::OP_LOAD : jcm_pkg::OP_IDLE;
            S_SQX:   cmd.op = jcm_pkg::OP_SQX;
            S_SQY:   cmd.op = jcm_pkg::OP_SQY;
            S_SQD:   cmd.op = jcm_pkg::OP_SQD;
            S_TEST:  cmd.op = jcm_pkg::OP_TEST;
            S_ROOT:  cmd.op = jcm_pkg::OP_ROOT;
            S_OVER:  cmd.op = jcm_pkg::OP_OVER;
            S_MX1:   cmd.op = jcm_pkg::OP_MX1;
            S_MX2:   cmd.op = jcm_pkg::OP_MX2;
            S_MY1:   cmd.op = jcm_pkg::OP_MY1;
            S_MY2:   cmd.op = jcm_pkg::OP_MY2;
            S_DINIT: cmd.op = jcm_pkg::OP_DINIT;
            S_DIV:   cmd.op = jcm_pkg::OP_DIV;
            S_MOVE:  cmd.op = status.out_free ? jcm_pkg::OP_MOVE : jcm_pkg::OP_IDLE;
            default: cmd.op = jcm_pkg::OP_IDLE;
        endcase
    end

endmodule

>>> rtl/jcm_dp.sv
module jcm_dp #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  jcm_pkg::jcm_cmd_t            cmd,
    output jcm_pkg::jcm_status_t         status,
    input  jcm_pkg::jcm_cfg_t            cfg,
    input  logic signed [15:0]           stick_x,
    input  logic signed [15:0]           stick_y,
    input  logic signed [COORD_BITS-1:0] cursor_x,
    input  logic signed [COORD_BITS-1:0] cursor_y,
    input  logic [31:0]                  now_ms,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic signed [COORD_BITS-1:0] new_cursor_x,
    output logic signed [COORD_BITS-1:0] new_cursor_y,
    output logic                         stick_active
);

    localparam int SH  = 32 - FRACTION_BITS;        // drop of the Q0.32 gain down to Q.F
    localparam int NW  = 63 - SH;                   // quotient (step magnitude) width
    localparam int NWE = NW + (NW % 2);             // padded to whole radix-4 digits
    localparam int PW  = ((COORD_BITS > 32) ? COORD_BITS : 32) + FRACTION_BITS + 3;
    localparam int IW  = PW - FRACTION_BITS;

    localparam logic signed [IW-1:0] SAT_HI = IW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [IW-1:0] SAT_LO = IW'(-(64'sd1 <<< (COORD_BITS - 1)));

    // Two restoring divide steps: remainder stays below d, so 15 bits hold it
    function automatic logic [NWE+14:0] div_step2(
        input logic [14:0]    r,
        input logic [NWE-1:0] q,
        input logic [14:0]    d
    );
        logic [15:0]    t;
        logic [14:0]    rr;
        logic [NWE-1:0] qq;
        rr = r;
        qq = q;
        for (int i = 0; i < 2; i++) begin
            t  = {rr, qq[NWE-1]};
            qq = {qq[NWE-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t     = t - {1'b0, d};
                qq[0] = 1'b1;
            end
            rr = t[14:0];
        end
        return {rr, qq};
    endfunction

    // Position = cursor + carry +/- step, split toward zero, then clamp
    function automatic logic [COORD_BITS+FRACTION_BITS:0] move_axis(
        input logic signed [COORD_BITS-1:0]  cur,
        input logic signed [FRACTION_BITS:0] car,
        input logic [NW-1:0]                 mag,
        input logic                          neg
    );
        logic signed [PW-1:0]     pos;
        logic signed [IW-1:0]     ip;
        logic [FRACTION_BITS-1:0] frac;
        logic signed [IW-1:0]     outv;
        logic [FRACTION_BITS:0]   rest;
        pos = (PW'(cur) <<< FRACTION_BITS) + PW'(car);
        if (neg) begin
            pos = pos - PW'(mag);
        end else begin
            pos = pos + PW'(mag);
        end
        ip   = pos[PW-1:FRACTION_BITS];
        frac = pos[FRACTION_BITS-1:0];
        if (pos[PW-1] && (frac != '0)) begin
            outv = ip + IW'(1);
            rest = {1'b1, frac};
        end else begin
            outv = ip;
            rest = {1'b0, frac};
        end
        if (outv > SAT_HI) begin
            outv = SAT_HI;
            rest = '0;
        end else if (outv < SAT_LO) begin
            outv = SAT_LO;
            rest = '0;
        end
        return {outv[COORD_BITS-1:0], rest};
    endfunction

    // Item registers
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [31:0]                  now_reg;
    logic [15:0]                  ax_reg, ay_reg;
    logic                         negx_reg, negy_reg;
    logic                         act_reg;

    // Shared multiplier and intermediate values
    logic [63:0]    prod_reg;
    logic [31:0]    lensq_reg;
    logic [31:0]    gain_reg;
    logic [31:0]    rv_reg, res_reg, rbit_reg;
    logic [15:0]    over_reg;
    logic [NWE-1:0] qx_reg, qy_reg;
    logic [14:0]    rx_reg, ry_reg;

    // Carried state
    logic [31:0]                  slow_until_reg;
    logic signed [FRACTION_BITS:0] carry_x_reg, carry_y_reg;

    // Output register
    logic                         ovalid_reg;
    logic                         oact_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [15:0] ax_w, ay_w;
    logic        lens_gt;
    logic [14:0] denom;
    logic [31:0] trial;
    logic        root_ge;
    logic [NWE+14:0] divx_w, divy_w;
    logic [COORD_BITS+FRACTION_BITS:0] movx_w, movy_w;

    assign ax_w    = stick_x[15] ? (~stick_x + 16'd1) : stick_x;
    assign ay_w    = stick_y[15] ? (~stick_y + 16'd1) : stick_y;
    assign lens_gt = lensq_reg > prod_reg[31:0];
    assign denom   = (cfg.rest_radius == jcm_pkg::STICK_FULL) ? 15'd1
                                                              : jcm_pkg::STICK_FULL - cfg.rest_radius;
    assign trial   = res_reg + rbit_reg;
    assign root_ge = rv_reg >= trial;
    assign divx_w  = div_step2(rx_reg, qx_reg, denom);
    assign divy_w  = div_step2(ry_reg, qy_reg, denom);
    assign movx_w  = move_axis(cx_reg, carry_x_reg, qx_reg[NW-1:0], negx_reg);
    assign movy_w  = move_axis(cy_reg, carry_y_reg, qy_reg[NW-1:0], negy_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op) inside
            jcm_pkg::OP_SQX: begin
                mul_a = 32'(ax_reg);
                mul_b = 32'(ax_reg);
            end
            jcm_pkg::OP_SQY: begin
                mul_a = 32'(ay_reg);
                mul_b = 32'(ay_reg);
            end
            jcm_pkg::OP_SQD: begin
                mul_a = 32'(cfg.rest_radius);
                mul_b = 32'(cfg.rest_radius);
            end
            jcm_pkg::OP_MX1: begin
                mul_a = 32'(over_reg);
                mul_b = 32'(ax_reg);
            end
            jcm_pkg::OP_MY1: begin
                mul_a = 32'(over_reg);
                mul_b = 32'(ay_reg);
            end
            jcm_pkg::OP_MX2, jcm_pkg::OP_MY2: begin
                mul_a = prod_reg[31:0];
                mul_b = gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign status.active   = lens_gt;
    assign status.out_free = !ovalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        unique case (cmd.op) inside
            jcm_pkg::OP_LOAD: begin
                cx_reg   <= cursor_x;
                cy_reg   <= cursor_y;
                now_reg  <= now_ms;
                ax_reg   <= ax_w;
                ay_reg   <= ay_w;
                negx_reg <= stick_x[15];
                negy_reg <= !stick_y[15];
            end
            jcm_pkg::OP_SQX: prod_reg <= mul_p;
            jcm_pkg::OP_SQY: begin
                prod_reg  <= mul_p;
                lensq_reg <= prod_reg[31:0];
            end
            jcm_pkg::OP_SQD: begin
                prod_reg  <= mul_p;
                lensq_reg <= lensq_reg + prod_reg[31:0];
            end
            jcm_pkg::OP_TEST: begin
                // keep the flag off the output register until the final step
                act_reg  <= lens_gt;
                gain_reg <= (now_reg >= slow_until_reg) ? cfg.fast_gain : cfg.slow_gain;
                rv_reg   <= lensq_reg;
                res_reg  <= '0;
                rbit_reg <= jcm_pkg::ROOT_FIRST_BIT;
                qx_reg   <= '0;
                qy_reg   <= '0;
            end
            jcm_pkg::OP_ROOT: begin
                if (root_ge) begin
                    rv_reg  <= rv_reg - trial;
                    res_reg <= (res_reg >> 1) + rbit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                rbit_reg <= rbit_reg >> 2;
            end
            jcm_pkg::OP_OVER: begin
                over_reg <= (res_reg > 32'(cfg.rest_radius))
                            ? 16'(res_reg - 32'(cfg.rest_radius)) : 16'd0;
            end
            jcm_pkg::OP_MX1, jcm_pkg::OP_MX2, jcm_pkg::OP_MY2: prod_reg <= mul_p;
            jcm_pkg::OP_MY1: begin
                prod_reg <= mul_p;
                qx_reg   <= NWE'(prod_reg[62:SH]);
            end
            jcm_pkg::OP_DINIT: begin
                qy_reg <= NWE'(prod_reg[62:SH]);
                rx_reg <= '0;
                ry_reg <= '0;
            end
            jcm_pkg::OP_DIV: begin
                {rx_reg, qx_reg} <= divx_w;
                {ry_reg, qy_reg} <= divy_w;
            end
            jcm_pkg::OP_MOVE: begin
                ox_reg   <= movx_w[COORD_BITS+FRACTION_BITS:FRACTION_BITS+1];
                oy_reg   <= movy_w[COORD_BITS+FRACTION_BITS:FRACTION_BITS+1];
                oact_reg <= act_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_until_reg <= '0;
            carry_x_reg    <= '0;
            carry_y_reg    <= '0;
            ovalid_reg     <= 1'b0;
        end else begin
            // resting stick restarts the slow phase
            if ((cmd.op == jcm_pkg::OP_TEST) && !lens_gt) begin
                slow_until_reg <= now_reg + 32'(cfg.hold_delay_ms);
            end
            if (cmd.op == jcm_pkg::OP_MOVE) begin
                carry_x_reg <= movx_w[FRACTION_BITS:0];
                carry_y_reg <= movy_w[FRACTION_BITS:0];
                ovalid_reg  <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid     = ovalid_reg;
    assign new_cursor_x = ox_reg;
    assign new_cursor_y = oy_reg;
    assign stick_active = oact_reg;

endmodule

>>> rtl/joystick_cursor_mover.sv
// Channel   Dir  Payload                                              Handshake
// s_        in   stick_x, stick_y, cursor_x, cursor_y, now_ms          tvalid/tready
// m_        out  new_cursor_x, new_cursor_y, stick_active              tvalid/tready
// cfg_      in   rest_radius, fast_gain, slow_gain, hold_delay_ms      cfg_wr_en
//
// One item at a time. From accept to result, a moving stick runs 16 root steps and
// DIV_STEPS = ceil((31+F)/2) radix-4 divide steps, both axes divided side by side;
// a resting stick skips the root, gain and divide steps.
// s_tready rises at the edge the result enters the output register, which holds it
// while m_tready is low; a full output register stalls the final step.
// aresetn is synchronous, active low; s_tready rises in the cycle after reset is released.
module joystick_cursor_mover #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 24,
    localparam int S_W = ((64 + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int M_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // stick_x[16], stick_y[16], cursor_x[COORD_BITS], cursor_y[COORD_BITS], now_ms[32]
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // new_cursor_x[COORD_BITS], new_cursor_y[COORD_BITS], stick_active[1]
    output logic [M_W-1:0] m_tdata,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wdata
);

    localparam int NW        = 31 + FRACTION_BITS;
    localparam int DIV_STEPS = (NW + (NW % 2)) / 2;

    jcm_pkg::jcm_cfg_t    cfg_reg;
    jcm_pkg::jcm_cmd_t    cmd;
    jcm_pkg::jcm_status_t status;

    logic signed [COORD_BITS-1:0] new_cursor_x, new_cursor_y;
    logic                         stick_active;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rest_radius   <= jcm_pkg::REST_RADIUS_RST;
            cfg_reg.fast_gain     <= jcm_pkg::FAST_GAIN_RST;
            cfg_reg.slow_gain     <= jcm_pkg::SLOW_GAIN_RST;
            cfg_reg.hold_delay_ms <= jcm_pkg::HOLD_DELAY_RST;
        end else if (cfg_wr_en) begin
            unique case (jcm_pkg::jcm_reg_t'(cfg_index))
                jcm_pkg::REG_REST_RADIUS: cfg_reg.rest_radius   <= cfg_wdata[14:0];
                jcm_pkg::REG_FAST_GAIN:   cfg_reg.fast_gain     <= cfg_wdata;
                jcm_pkg::REG_SLOW_GAIN:   cfg_reg.slow_gain     <= cfg_wdata;
                jcm_pkg::REG_HOLD_DELAY:  cfg_reg.hold_delay_ms <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    jcm_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jcm_dp #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg_reg),
        .stick_x      (s_tdata[15:0]),
        .stick_y      (s_tdata[31:16]),
        .cursor_x     (s_tdata[32+COORD_BITS-1:32]),
        .cursor_y     (s_tdata[32+2*COORD_BITS-1:32+COORD_BITS]),
        .now_ms       (s_tdata[32+2*COORD_BITS+31:32+2*COORD_BITS]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .new_cursor_x (new_cursor_x),
        .new_cursor_y (new_cursor_y),
        .stick_active (stick_active)
    );

    assign m_tdata = M_W'({stick_active, new_cursor_y, new_cursor_x});

    // one item in flight: no second accept right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item in flight");

    // a result shows up only as the controller returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $rose(s_tready))
        else $error("result appeared outside the final step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == jcm_pkg::OP_MOVE) |-> status.out_free)
        else $error("final step issued while output register is full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == jcm_pkg::OP_LOAD) |-> (s_tvalid && s_tready))
        else $error("input load without handshake");

endmodule

>>> bench/cursor_move_checker.sv
`timescale 1ns / 1ps

module cursor_move_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // stick_x[15:0], stick_y[31:16], cursor_x[47:32], cursor_y[63:48], now_ms[95:64]
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // new_cursor_x[15:0], new_cursor_y[31:16], stick_active[32]
    input  logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          mismatches,
    output int          pending,
    output int          updates_seen,
    output int          active_seen
);

    localparam int     FRAC_W   = 24;
    localparam int     CRD_W    = 16;
    localparam longint FRAC_ONE = longint'(1) << FRAC_W;
    localparam longint CRD_HI   = (longint'(1) << (CRD_W - 1)) - 1;
    localparam longint CRD_LO   = -CRD_HI - 1;

    typedef struct packed {
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        logic               active;
    } cursor_upd_t;

    typedef struct packed {
        logic signed [15:0] pix;
        longint             rest;
    } axis_t;

    logic [14:0] rest_radius;
    logic [31:0] fast_gain;
    logic [31:0] slow_gain;
    logic [15:0] hold_delay;
    longint      carry_x;
    longint      carry_y;
    logic [31:0] slow_until;

    cursor_upd_t expected_moves[$];

    initial begin
        mismatches   = 0;
        pending      = 0;
        updates_seen = 0;
        active_seen  = 0;
    end

    function automatic longint stick_radius(input longint sq);
        longint r;
        longint t;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= sq) r = t;
        end
        return r;
    endfunction

    // Exact sum in Q.FRAC_W, then truncate toward zero and keep the rest as carry
    function automatic axis_t shift_axis(input longint cursor, input longint carry,
                                         input longint delta);
        longint pos;
        longint whole;
        axis_t  r;
        pos    = cursor * FRAC_ONE + carry + delta;
        whole  = pos / FRAC_ONE;
        r.rest = pos - whole * FRAC_ONE;
        if (whole > CRD_HI) begin
            whole  = CRD_HI;
            r.rest = 0;
        end else if (whole < CRD_LO) begin
            whole  = CRD_LO;
            r.rest = 0;
        end
        r.pix = whole[15:0];
        return r;
    endfunction

    function automatic cursor_upd_t predict_cursor_move(input logic [95:0] poll);
        shortint     sx, sy, cx, cy;
        logic [31:0] now;
        longint      ax, ay, radius_sq, dz, radius, over, denom, gain;
        longint      mag_x, mag_y, dx, dy;
        axis_t       ox, oy;
        cursor_upd_t upd;
        sx        = poll[15:0];
        sy        = poll[31:16];
        cx        = poll[47:32];
        cy        = poll[63:48];
        now       = poll[95:64];
        ax        = (sx < 0) ? -longint'(sx) : longint'(sx);
        ay        = (sy < 0) ? -longint'(sy) : longint'(sy);
        radius_sq = ax * ax + ay * ay;
        dz        = longint'(rest_radius);
        mag_x     = 0;
        mag_y     = 0;
        upd.active = (radius_sq > dz * dz);
        if (upd.active) begin
            radius = stick_radius(radius_sq);
            over   = (radius > dz) ? radius - dz : 0;
            denom  = longint'(jcm_pkg::STICK_FULL) - dz;
            if (denom == 0) denom = 1;
            gain   = (now >= slow_until) ? longint'(fast_gain) : longint'(slow_gain);
            mag_x  = ((gain * over * ax) / denom) >> (32 - FRAC_W);
            mag_y  = ((gain * over * ay) / denom) >> (32 - FRAC_W);
        end else begin
            // resting stick restarts the slow phase
            slow_until = now + {16'd0, hold_delay};
        end
        // stick up is positive, screen Y grows downward
        dx = (sx < 0) ? -mag_x : mag_x;
        dy = (sy < 0) ? mag_y : -mag_y;
        ox = shift_axis(cx, carry_x, dx);
        oy = shift_axis(cy, carry_y, dy);
        carry_x   = ox.rest;
        carry_y   = oy.rest;
        upd.cur_x = ox.pix;
        upd.cur_y = oy.pix;
        return upd;
    endfunction

    always @(posedge aclk) begin : watch
        cursor_upd_t got;
        cursor_upd_t want;
        if (!aresetn) begin
            rest_radius = jcm_pkg::REST_RADIUS_RST;
            fast_gain   = jcm_pkg::FAST_GAIN_RST;
            slow_gain   = jcm_pkg::SLOW_GAIN_RST;
            hold_delay  = jcm_pkg::HOLD_DELAY_RST;
            carry_x     = 0;
            carry_y     = 0;
            slow_until  = '0;
            expected_moves.delete();
        end else begin
            if (cfg_wr_en) begin
                case (jcm_pkg::jcm_reg_t'(cfg_index))
                    jcm_pkg::REG_REST_RADIUS: rest_radius = cfg_wdata[14:0];
                    jcm_pkg::REG_FAST_GAIN:   fast_gain   = cfg_wdata;
                    jcm_pkg::REG_SLOW_GAIN:   slow_gain   = cfg_wdata;
                    jcm_pkg::REG_HOLD_DELAY:  hold_delay  = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // retire before predicting: a result can never belong to an item taken this edge
            if (m_tvalid && m_tready) begin
                got.cur_x  = m_tdata[15:0];
                got.cur_y  = m_tdata[31:16];
                got.active = m_tdata[32];
                updates_seen++;
                if (got.active) active_seen++;
                if (expected_moves.size() == 0) begin
                    $error("cursor update with no poll outstanding");
                    mismatches++;
                end else begin
                    want = expected_moves.pop_front();
                    if (got.cur_x !== want.cur_x) begin
                        $error("new_cursor_x: expected %0d, got %0d", want.cur_x, got.cur_x);
                        mismatches++;
                    end
                    if (got.cur_y !== want.cur_y) begin
                        $error("new_cursor_y: expected %0d, got %0d", want.cur_y, got.cur_y);
                        mismatches++;
                    end
                    if (got.active !== want.active) begin
                        $error("stick_active: expected %0d, got %0d", want.active,
                               got.active);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) expected_moves.push_back(predict_cursor_move(s_tdata));
        end
        pending <= expected_moves.size();
    end

endmodule

>>> bench/joystick_cursor_mover_tb.sv
`timescale 1ns / 1ps

module joystick_cursor_mover_tb;

    localparam int          CYCLE_LIMIT   = 1_500_000;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          PHASE_POLLS   = 185;
    localparam logic [15:0] STK_MAX       = 16'h7FFF;
    localparam logic [15:0] STK_MIN       = 16'h8000;

    typedef enum logic [1:0] {
        RUN_REST,
        RUN_PUSH,
        RUN_NOISE
    } run_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int mismatches;
    int pending;
    int updates_seen;
    int active_seen;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cur_dz         = 25000;
    int settings       = 1;
    int cycle_cnt      = 0;

    joystick_cursor_mover u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    cursor_move_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .updates_seen (updates_seen),
        .active_seen  (active_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random stalls, plus a long hold-off when requested
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Timed out after %0d cycles with %0d updates outstanding", cycle_cnt, pending);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [15:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return STK_MAX;
            1:       return STK_MIN;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_within(input int lim);
        int v;
        v = $urandom_range(0, lim);
        if ($urandom_range(0, 1)) v = -v;
        return 16'(v);
    endfunction

    task automatic send_poll(input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] cx, input logic [15:0] cy,
                             input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, cy, cx, sy, sx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid, wait for every outstanding update, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_regs(input logic [14:0] dz, input logic [31:0] fg,
                             input logic [31:0] sg, input logic [15:0] hd);
        cfg_wr_en <= 1'b1;
        cfg_index <= jcm_pkg::REG_REST_RADIUS;
        cfg_wdata <= {17'd0, dz};
        @(posedge aclk);
        cfg_index <= jcm_pkg::REG_FAST_GAIN;
        cfg_wdata <= fg;
        @(posedge aclk);
        cfg_index <= jcm_pkg::REG_SLOW_GAIN;
        cfg_wdata <= sg;
        @(posedge aclk);
        cfg_index <= jcm_pkg::REG_HOLD_DELAY;
        cfg_wdata <= {16'd0, hd};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_dz = dz;
        settings++;
    endtask

    initial begin
        int          r;
        int          run_left;
        run_kind_t   run_kind;
        logic [15:0] sx, sy, cx, cy, mag, other;
        logic [31:0] now_ms;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= jcm_pkg::REG_REST_RADIUS;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: slow and fast gain, radius exactly at the dead zone,
        // and the slow phase end wrapping past 2^32
        send_poll(16'd0, 16'd0, 16'd0, 16'd0, 32'd1000);
        send_poll(STK_MAX, 16'd0, 16'd100, -16'd100, 32'd1200);
        send_poll(16'd0, STK_MIN, 16'd100, -16'd100, 32'd1500);
        send_poll(STK_MIN, STK_MIN, 16'd0, 16'd0, 32'd1600);
        send_poll(STK_MAX, STK_MAX, STK_MIN, STK_MAX, 32'd1620);
        send_poll(16'd25000, 16'd1, 16'd5, 16'd5, 32'd1640);
        send_poll(16'd25000, 16'd0, 16'd5, 16'd5, 32'd1660);
        send_poll(16'd0, 16'd0, 16'd9, 16'd9, 32'hFFFF_FFFF);
        send_poll(STK_MIN, STK_MAX, 16'd0, 16'd0, 32'd100);
        send_poll(STK_MAX, STK_MIN, 16'd0, 16'd0, 32'hFFFF_FFF0);
        wait_idle();

        // No dead zone, full fast gain: tiny steps and saturation on both axes
        load_regs(15'd0, 32'hFFFF_FFFF, 32'd0, 16'd0);
        send_poll(16'd0, 16'd0, 16'd7, -16'd7, 32'd10);
        send_poll(16'd1, 16'd0, 16'd0, 16'd0, 32'd10);
        send_poll(STK_MAX, STK_MAX, STK_MAX, STK_MIN, 32'd20);
        send_poll(STK_MIN, STK_MIN, STK_MIN, STK_MAX, 32'd25);
        send_poll(16'hFFFF, 16'd1, 16'd0, 16'd0, 32'd30);
        send_poll(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 32'd40);
        wait_idle();

        // Full dead zone: only the most negative axis or a full diagonal gets past it
        load_regs(jcm_pkg::STICK_FULL, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_poll(STK_MAX, STK_MAX, 16'd0, 16'd0, 32'd0);
        send_poll(STK_MIN, STK_MIN, 16'd0, 16'd0, 32'd50);
        send_poll(STK_MAX, 16'd0, 16'd0, 16'd0, 32'd60);
        send_poll(STK_MIN, 16'd0, 16'd1, 16'd1, 32'd70);

        run_left = 0;
        run_kind = RUN_NOISE;
        now_ms   = 32'd0;
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0: load_regs(jcm_pkg::REST_RADIUS_RST, jcm_pkg::FAST_GAIN_RST,
                             jcm_pkg::SLOW_GAIN_RST, jcm_pkg::HOLD_DELAY_RST);
                1: load_regs(15'd0, 32'hFFFF_FFFF, 32'd0, 16'd0);
                2: load_regs(jcm_pkg::STICK_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
                default: load_regs(15'($urandom_range(0, 32767)),
                                   $urandom >> $urandom_range(0, 24),
                                   $urandom >> $urandom_range(0, 24),
                                   ($urandom_range(0, 3) != 0) ?
                                       16'($urandom_range(0, 1000)) : 16'($urandom));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            // hold results back long enough for the block to stall its input
            if (p == 0) hold_left = 400;

            for (int i = 0; i < PHASE_POLLS; i++) begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 3);
                    run_kind = (r == 0) ? RUN_REST : (r == 3) ? RUN_NOISE : RUN_PUSH;
                    case (run_kind)
                        RUN_REST: run_left = $urandom_range(1, 8);
                        RUN_PUSH: run_left = $urandom_range(5, 80);
                        default:  run_left = $urandom_range(1, 10);
                    endcase
                end
                run_left--;

                case (run_kind)
                    RUN_REST: begin
                        sx = rand_within(cur_dz * 7 / 10);
                        sy = rand_within(cur_dz * 7 / 10);
                    end
                    RUN_PUSH: begin
                        mag   = 16'($urandom_range(cur_dz, 32767));
                        other = 16'($urandom);
                        if ($urandom_range(0, 1)) mag = -mag;
                        if ($urandom_range(0, 1)) begin
                            sx = mag;
                            sy = other;
                        end else begin
                            sx = other;
                            sy = mag;
                        end
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0, 1: begin
                                sx = 16'($urandom);
                                sy = 16'($urandom);
                            end
                            2: begin
                                sx = pick_edge();
                                sy = pick_edge();
                            end
                            default: begin
                                // straddle the dead zone edge
                                sx = 16'(cur_dz + int'($urandom_range(0, 2)) - 1);
                                sy = 16'($urandom_range(0, 2));
                            end
                        endcase
                    end
                endcase

                cx = ($urandom_range(0, 9) == 0) ? pick_edge() : 16'($urandom);
                cy = ($urandom_range(0, 9) == 0) ? pick_edge() : 16'($urandom);

                r = $urandom_range(0, 99);
                if (r < 3) now_ms = $urandom;
                else if (r < 4) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
                else now_ms = now_ms + $urandom_range(1, 33);

                send_poll(sx, sy, cx, cy, now_ms);
            end
        end
        wait_idle();

        $display("Checked %0d cursor updates, %0d with the stick out of the dead zone,",
                 updates_seen, active_seen);
        $display("under %0d register settings and four mixes of idle and stall", settings);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/jcm_pkg.sv
rtl/jcm_ctrl.sv
rtl/jcm_dp.sv
rtl/joystick_cursor_mover.sv
bench/cursor_move_checker.sv
bench/joystick_cursor_mover_tb.sv
